/* design/msdc_pkg.sv */
// Package for the motion sensor debounce counter.
// Holds the state and snapshot structs, register indexes and action codes.
// No dependencies.
`default_nettype none

package msdc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned FiltW   = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 32;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_WARMUP = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_FILTER = 1'd1;

  // Action codes of an input request
  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [TimeW-1:0] WARMUP_RESET = 32'd60000;
  localparam logic [FiltW-1:0] FILTER_RESET = 16'd50;

  // Debounce and warm-up state carried from request to request
  typedef struct packed {
    logic             raw;
    logic             stable;
    logic             cand;
    logic             cand_counts;
    logic             ready;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] cand_time;
    logic [TimeW-1:0] event_total;
    logic [TimeW-1:0] motion_time;
  } state_t;

  // Snapshot returned for every request
  typedef struct packed {
    logic             ready_res;
    logic             raw_level;
    logic             motion_active;
    logic [TimeW-1:0] motion_events;
    logic [TimeW-1:0] last_motion_time;
    logic [TimeW-1:0] warmup_remaining;
  } snap_t;

  // One registered request
  typedef struct packed {
    logic             action;
    logic [TimeW-1:0] now_time;
    logic             level;
  } req_t;

endpackage

`default_nettype wire

/* design/msdc_update.sv */
// Next-state and snapshot logic for one request of the debounce counter.
// Pure combinational; uses msdc_pkg.
`default_nettype none

module msdc_update
  import msdc_pkg::*;
(
  input  req_t             req_i,
  input  state_t           state_i,
  input  logic [TimeW-1:0] warmup_time_i,
  input  logic [FiltW-1:0] filter_time_i,
  output state_t           state_o,
  output snap_t            snap_o
);

  logic             chg;
  logic             cand_n;
  logic             cc_n;
  logic [TimeW-1:0] ct_n;
  logic [TimeW-1:0] held;
  logic             promote;
  logic             count_evt;
  logic [TimeW-1:0] since_start;
  logic [TimeW-1:0] elapsed;

  // Sample path
  assign chg       = req_i.level != state_i.cand;
  assign cand_n    = chg ? req_i.level : state_i.cand;
  assign cc_n      = chg ? state_i.ready : state_i.cand_counts;
  assign ct_n      = chg ? req_i.now_time : state_i.cand_time;
  assign held      = req_i.now_time - ct_n;
  assign promote   = (cand_n != state_i.stable) && (held >= TimeW'(filter_time_i));
  assign count_evt = promote && cc_n && !state_i.stable && cand_n;
  assign since_start = req_i.now_time - state_i.start_time;

  always_comb begin
    if (req_i.action == ACT_RESTART) begin
      state_o.raw         = req_i.level;
      state_o.stable      = req_i.level;
      state_o.cand        = req_i.level;
      state_o.cand_counts = 1'b0;
      state_o.ready       = 1'b0;
      state_o.start_time  = req_i.now_time;
      state_o.cand_time   = req_i.now_time;
      state_o.event_total = '0;
      state_o.motion_time = '0;
    end else begin
      state_o.raw         = req_i.level;
      state_o.stable      = promote ? cand_n : state_i.stable;
      state_o.cand        = cand_n;
      state_o.cand_counts = promote ? 1'b0 : cc_n;
      state_o.ready       = state_i.ready || (since_start >= warmup_time_i);
      state_o.start_time  = state_i.start_time;
      state_o.cand_time   = ct_n;
      state_o.event_total = count_evt ? state_i.event_total + 1'b1 : state_i.event_total;
      state_o.motion_time = count_evt ? req_i.now_time : state_i.motion_time;
    end
  end

  // Latest time is always this request's time, so elapsed follows from it
  assign elapsed = req_i.now_time - state_o.start_time;

  always_comb begin
    snap_o.ready_res        = state_o.ready;
    snap_o.raw_level        = state_o.raw;
    snap_o.motion_active    = state_o.ready && state_o.stable;
    snap_o.motion_events    = state_o.event_total;
    snap_o.last_motion_time = state_o.motion_time;
    snap_o.warmup_remaining = (!state_o.ready && (elapsed < warmup_time_i))
                              ? (warmup_time_i - elapsed) : '0;
  end

endmodule

`default_nettype wire

/* design/motion_sensor_debounce_counter.sv */
// Motion sensor debounce counter with warm-up: top level.
// Input register, state registers, result register; uses msdc_pkg, msdc_update.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: action
//   (sample or restart), a millisecond timestamp and the raw sensor level.
//   Output channel (out_valid_o / out_stall_i) returns one snapshot per
//   request, in order: ready flag, raw level, debounced motion, event count,
//   time of the last counted event and warm-up time left.
//   A snapshot is registered in the result register after its request leaves
//   the input register. Throughput is one request per cycle while the output
//   is not stalled; the state update is a few 32-bit subtractions and compares
//   between the input register and the state and result registers.
//   A stalled output holds its snapshot; the input register then holds its
//   request and in_stall_o rises only while that register is full.
//   Reset clears all debounce state as if restarted at time 0 with level 0,
//   loads warmup_time 60000 and stable_filter_time 50, and empties both
//   stages. Write the configuration registers only while no request is in
//   flight.
`default_nettype none

module motion_sensor_debounce_counter
  import msdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [TimeW-1:0]   now_time_i,
  input  logic               level_sample_i,
  // snapshot channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ready_res_o,
  output logic               raw_level_o,
  output logic               motion_active_o,
  output logic [TimeW-1:0]   motion_events_o,
  output logic [TimeW-1:0]   last_motion_time_o,
  output logic [TimeW-1:0]   warmup_remaining_o
);

  logic [TimeW-1:0] warmup_time_q;
  logic [FiltW-1:0] filter_time_q;

  logic   req_valid_q;
  req_t   req_q;
  state_t state_q, state_d;
  logic   out_valid_q;
  snap_t  snap_q, snap_d;

  logic   in_fire;
  logic   advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warmup_time_q <= WARMUP_RESET;
      filter_time_q <= FILTER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WARMUP: warmup_time_q <= cfg_data_i;
        CFG_FILTER: filter_time_q <= cfg_data_i[FiltW-1:0];
        default:    ;
      endcase
    end
  end

  // Move the registered request on whenever the result register is free
  assign advance    = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_fire) begin
      req_valid_q <= 1'b1;
    end else if (advance) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.action   <= action_i;
      req_q.now_time <= now_time_i;
      req_q.level    <= level_sample_i;
    end
  end

  msdc_update u_update (
    .req_i         (req_q),
    .state_i       (state_q),
    .warmup_time_i (warmup_time_q),
    .filter_time_i (filter_time_q),
    .state_o       (state_d),
    .snap_o        (snap_d)
  );

  // Commit state as the request leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      snap_q <= snap_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign ready_res_o        = snap_q.ready_res;
  assign raw_level_o        = snap_q.raw_level;
  assign motion_active_o    = snap_q.motion_active;
  assign motion_events_o    = snap_q.motion_events;
  assign last_motion_time_o = snap_q.last_motion_time;
  assign warmup_remaining_o = snap_q.warmup_remaining;

  // Stall only when the input register is full
  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_valid_q |-> !in_stall_o)
    else $error("input stalled with empty request register");

  // Event count steps by at most one per request, or clears on restart
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (state_q.event_total == $past(state_q.event_total)) ||
                (state_q.event_total == $past(state_q.event_total) + 1'b1) ||
                (state_q.event_total == '0))
    else $error("event count jumped");

  // A ready snapshot has no warm-up left and motion implies ready
  a_snap_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!ready_res_o || (warmup_remaining_o == '0)) &&
                    (!motion_active_o || ready_res_o))
    else $error("inconsistent snapshot");

  // Nothing leaves the input register while the result register is blocked
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(snap_q))
    else $error("snapshot overwritten under stall");

endmodule

`default_nettype wire
